// ----- design/tmrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// tmrgb_pkg: shared types and constants of the ACES tone mapper
// Widths of the fixed-point datapath and the Q2.16 curve coefficients.
// ----------------------------------------------------------------------------
package tmrgb_pkg;

  localparam int CH_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int COEF_W  = 18;
  localparam int INNER_W = 35;
  localparam int PROD_W  = 52;
  localparam int DIV_STAGES = BYTE_W;
  localparam int REM_W   = PROD_W + BYTE_W;
  localparam int FRONT_STAGES = 3;
  localparam int LANE_STAGES  = FRONT_STAGES + DIV_STAGES;

  localparam logic [COEF_W-1:0] COEF_A = 18'd164495;
  localparam logic [COEF_W-1:0] COEF_B = 18'd1966;
  localparam logic [COEF_W-1:0] COEF_C = 18'd159252;
  localparam logic [COEF_W-1:0] COEF_D = 18'd38666;
  localparam logic [COEF_W-1:0] COEF_E = 18'd9175;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LANE_STAGES-1:0] stage_vec_t;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
  } rgb8_t;

endpackage

// ----- design/aces_tonemap_to_rgb8.sv -----
// ----------------------------------------------------------------------------
// aces_tonemap_to_rgb8: ACES filmic tone mapping of linear HDR to RGB bytes
// Three channel lanes evaluate the filmic curve in fixed point side by side;
// an output register merges them into one byte triple per pixel.
//
//   channel  signals                               role
//   in       in_valid in_ready in_red/green/blue   linear pixel, unsigned
//   out      out_valid out_ready out_red/green/blue tone mapped bytes
//
// One pixel is accepted per clock while in_ready is high. The accepting edge
// loads the first of 3 stages of curve arithmetic, followed by
// 8 stages of division, one quotient bit each, and the output register.
// Reset clears the stage valid bits and the output valid only.
// A stall at the output fills empty stages first; in_ready falls only when
// every stage and the output register hold a transaction.
// ----------------------------------------------------------------------------
module aces_tonemap_to_rgb8 #(
  parameter int IN_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_red,
  input  logic [15:0]           in_green,
  input  logic [15:0]           in_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue
);

  localparam int NST = tmrgb_pkg::LANE_STAGES;

  tmrgb_pkg::stage_vec_t v_r, v_nxt, ld;
  tmrgb_pkg::rgb8_t      lane_rgb, out_rgb;
  logic                  out_ld;

  always_comb begin
    ld[NST-1] = !v_r[NST-1] || out_ld;
    for (int i = NST - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = ld[0] ? in_valid : v_r[0];
    for (int i = 1; i < NST; i++) begin
      v_nxt[i] = ld[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = ld[0];

  tmrgb_lane #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_lane_red (
    .clk (clk),
    .en  (ld),
    .x   (in_red),
    .y   (lane_rgb.red)
  );

  tmrgb_lane #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_lane_green (
    .clk (clk),
    .en  (ld),
    .x   (in_green),
    .y   (lane_rgb.green)
  );

  tmrgb_lane #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_lane_blue (
    .clk (clk),
    .en  (ld),
    .x   (in_blue),
    .y   (lane_rgb.blue)
  );

  tmrgb_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (v_r[NST-1]),
    .lane_rgb   (lane_rgb),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_rgb    (out_rgb),
    .load       (out_ld)
  );

  assign out_red   = out_rgb.red;
  assign out_green = out_rgb.green;
  assign out_blue  = out_rgb.blue;

  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0) && !out_valid |-> in_ready)
    else $error("in_ready low with an empty pipeline");

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r == '1) && out_valid)
    else $error("input stalled while the pipeline has a free stage");

  a_last_held : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !out_ld |=> v_r[NST-1])
    else $error("last lane stage lost a transaction");

  a_out_refill : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && v_r[NST-1] |=> out_valid)
    else $error("waiting transaction did not reach the output register");

endmodule

// ----- design/tmrgb_lane.sv -----
// ----------------------------------------------------------------------------
// tmrgb_lane: one color channel of the tone mapper
// Builds numerator and denominator of the curve, then a pipelined restoring
// division yields floor(255*N/D), one quotient bit per stage.
// ----------------------------------------------------------------------------
module tmrgb_lane #(
  parameter int IN_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  tmrgb_pkg::stage_vec_t en,
  input  tmrgb_pkg::chan_t      x,
  output tmrgb_pkg::byte_t      y
);

  localparam int INNER_W = tmrgb_pkg::INNER_W;
  localparam int PROD_W  = tmrgb_pkg::PROD_W;
  localparam int REM_W   = tmrgb_pkg::REM_W;
  localparam int CH_W    = tmrgb_pkg::CH_W;
  localparam int COEF_W  = tmrgb_pkg::COEF_W;
  localparam int BYTE_W  = tmrgb_pkg::BYTE_W;
  localparam int NDIV    = tmrgb_pkg::DIV_STAGES;
  localparam int FRONT   = tmrgb_pkg::FRONT_STAGES;

  localparam logic [INNER_W-1:0] B_ONE = INNER_W'(tmrgb_pkg::COEF_B) << IN_FRAC_BITS;
  localparam logic [INNER_W-1:0] D_ONE = INNER_W'(tmrgb_pkg::COEF_D) << IN_FRAC_BITS;
  localparam logic [PROD_W-1:0]  E_ONE = PROD_W'(tmrgb_pkg::COEF_E) << (2 * IN_FRAC_BITS);

  // Stage 1: inner linear terms.
  logic [CH_W-1:0]        x1_r;
  logic [INNER_W-1:0]     an_r, an_nxt;
  logic [INNER_W-1:0]     dn_r, dn_nxt;
  logic [COEF_W+CH_W-1:0] a_mul, c_mul;

  assign a_mul  = tmrgb_pkg::COEF_A * x;
  assign c_mul  = tmrgb_pkg::COEF_C * x;
  assign an_nxt = INNER_W'(a_mul) + B_ONE;
  assign dn_nxt = INNER_W'(c_mul) + D_ONE;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r <= x;
      an_r <= an_nxt;
      dn_r <= dn_nxt;
    end
  end

  // Stage 2: numerator and denominator.
  logic [CH_W+INNER_W-1:0] n_mul, d_mul;
  logic [PROD_W-1:0]       n_r, n_nxt;
  logic [PROD_W-1:0]       d_r, d_nxt;

  assign n_mul = x1_r * an_r;
  assign d_mul = x1_r * dn_r;
  assign n_nxt = PROD_W'(n_mul);
  assign d_nxt = PROD_W'(d_mul) + E_ONE;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n_r <= n_nxt;
      d_r <= d_nxt;
    end
  end

  // Stage 3: scaled dividend and saturation.
  logic [REM_W-1:0]  m_r, m_nxt;
  logic [PROD_W-1:0] d3_r;
  logic              sat3_r, sat3_nxt;

  assign m_nxt    = (REM_W'(n_r) << BYTE_W) - REM_W'(n_r);
  assign sat3_nxt = (n_r >= d_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m_r    <= m_nxt;
      d3_r   <= d_r;
      sat3_r <= sat3_nxt;
    end
  end

  // Division stages, most significant quotient bit first.
  logic [REM_W-1:0]  rem_r [NDIV];
  logic [PROD_W-1:0] dv_r  [NDIV];
  logic [BYTE_W-1:0] q_r   [NDIV];
  logic              sat_r [NDIV];

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [REM_W-1:0]  rem_in;
    logic [PROD_W-1:0] dv_in;
    logic [BYTE_W-1:0] q_in;
    logic              sat_in;
    logic [REM_W-1:0]  dsh;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [BYTE_W-1:0] q_nxt;

    if (j == 0) begin : g_first
      assign rem_in = m_r;
      assign dv_in  = d3_r;
      assign q_in   = '0;
      assign sat_in = sat3_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign dv_in  = dv_r[j-1];
      assign q_in   = q_r[j-1];
      assign sat_in = sat_r[j-1];
    end

    assign dsh     = REM_W'(dv_in) << (NDIV - 1 - j);
    assign ge      = (rem_in >= dsh);
    assign rem_nxt = ge ? (rem_in - dsh) : rem_in;
    assign q_nxt   = {q_in[BYTE_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (en[FRONT+j]) begin
        rem_r[j] <= rem_nxt;
        dv_r[j]  <= dv_in;
        q_r[j]   <= q_nxt;
        sat_r[j] <= sat_in;
      end
    end
  end

  assign y = sat_r[NDIV-1] ? {BYTE_W{1'b1}} : q_r[NDIV-1];

endmodule

// ----- design/tmrgb_merge.sv -----
// ----------------------------------------------------------------------------
// tmrgb_merge: output register of the tone mapper
// Joins the three lane results into one RGB transaction and holds it until
// the consumer takes it.
// ----------------------------------------------------------------------------
module tmrgb_merge (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             lane_valid,
  input  tmrgb_pkg::rgb8_t lane_rgb,
  input  logic             out_ready,
  output logic             out_valid,
  output tmrgb_pkg::rgb8_t out_rgb,
  output logic             load
);

  logic             valid_r, valid_nxt;
  tmrgb_pkg::rgb8_t rgb_r;

  assign load      = !valid_r || out_ready;
  assign valid_nxt = load ? lane_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_r <= lane_rgb;
    end
  end

  assign out_valid = valid_r;
  assign out_rgb   = rgb_r;

endmodule
